// File: rtl/core/idl_pkg.sv
// Shared definitions for the indexed insert/remove list.
// Holds command codes, fixed field widths and parameter defaults; no dependencies.
package idl_pkg;

  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned ITEM_WIDTH_DEF = 32;
  localparam int unsigned CMD_W          = 2;
  localparam int unsigned POS_W          = 4;
  localparam int unsigned VAL_W          = 32;
  localparam int unsigned LEN_W          = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_READ   = 2'd3
  } cmd_e;

endpackage

// File: rtl/core/idl_mem.sv
// Item store of the list: one write port and one read port, registered read data.
// Depends on idl_pkg for parameter defaults.
module idl_mem #(
  parameter int unsigned DEPTH      = idl_pkg::DEPTH_DEF,
  parameter int unsigned ITEM_WIDTH = idl_pkg::ITEM_WIDTH_DEF,
  parameter int unsigned AW         = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         waddr_i,
  input  logic [ITEM_WIDTH-1:0] wdata_i,
  input  logic                  re_i,
  input  logic [AW-1:0]         raddr_i,
  output logic [ITEM_WIDTH-1:0] rdata_o
);
  import idl_pkg::*;

  logic [ITEM_WIDTH-1:0] mem_q [DEPTH];
  logic [ITEM_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/indexed_insert_remove_list.sv
// Indexed insert/remove list: one request at a time, result held in an output register.
// Append, refused requests, insert at the end and removal of the last item go straight to the
// result; a read waits for the registered item store data; any other insert or remove at p
// first moves the items behind p through the item store one entry per cycle, n items held.
// A new request is taken only once the last result has moved to the output register.
// Reset empties the list; the item store itself is not cleared.
module indexed_insert_remove_list #(
  parameter int unsigned DEPTH      = idl_pkg::DEPTH_DEF,
  parameter int unsigned ITEM_WIDTH = idl_pkg::ITEM_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [idl_pkg::CMD_W-1:0]       cmd_i,
  input  logic [idl_pkg::POS_W-1:0]       position_i,
  input  logic signed [idl_pkg::VAL_W-1:0] value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            ok_o,
  output logic signed [idl_pkg::VAL_W-1:0] read_data_o,
  output logic [idl_pkg::LEN_W-1:0]       length_o,
  output logic                            empty_res_o
);
  import idl_pkg::*;

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RDWAIT = 3'd1;
  localparam logic [2:0] S_UP     = 3'd2;
  localparam logic [2:0] S_INSWR  = 3'd3;
  localparam logic [2:0] S_DN     = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]            state_q, state_d;
  logic [CW-1:0]         count_q, count_d;
  logic [AW-1:0]         rd_idx_q, rd_idx_d;
  logic [AW-1:0]         pos_q, pos_d;
  logic [ITEM_WIDTH-1:0] item_q, item_d;
  logic                  res_ok_q, res_ok_d;
  logic [VAL_W-1:0]      res_data_q, res_data_d;
  logic                  out_valid_q;
  logic                  ok_q;
  logic [VAL_W-1:0]      data_q;
  logic [LEN_W-1:0]      len_q;
  logic                  empty_q;

  logic                  accept;
  logic                  out_free;
  logic [CMPW-1:0]       posx, cntx, cnt_m1x, pos_p1x;
  logic [63:0]           val64;
  logic [ITEM_WIDTH-1:0] val_item;
  logic [63:0]           rd_pad;
  logic [VAL_W-1:0]      rd_ext;
  logic                  not_full;

  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [ITEM_WIDTH-1:0] mem_wdata, mem_rdata;

  idl_mem #(
    .DEPTH     (DEPTH),
    .ITEM_WIDTH(ITEM_WIDTH),
    .AW        (AW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign posx     = CMPW'(position_i);
  assign cntx     = CMPW'(count_q);
  assign cnt_m1x  = cntx - 1'b1;
  assign pos_p1x  = posx + 1'b1;
  assign not_full = (count_q < CW'(DEPTH));
  assign val64    = {{32{value_i[VAL_W-1]}}, value_i};
  assign rd_pad   = 64'(mem_rdata);

  always_comb begin
    for (int k = 0; k < ITEM_WIDTH; k++) begin
      val_item[k] = val64[k];
    end
    for (int k = 0; k < VAL_W; k++) begin
      rd_ext[k] = (k < ITEM_WIDTH) ? rd_pad[k] : mem_rdata[ITEM_WIDTH-1];
    end
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    rd_idx_d   = rd_idx_q;
    pos_d      = pos_q;
    item_d     = item_q;
    res_ok_d   = res_ok_q;
    res_data_d = res_data_q;
    mem_we     = 1'b0;
    mem_waddr  = count_q[AW-1:0];
    mem_wdata  = val_item;
    mem_re     = 1'b0;
    mem_raddr  = rd_idx_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          pos_d      = posx[AW-1:0];
          item_d     = val_item;
          res_ok_d   = 1'b0;
          res_data_d = '0;
          state_d    = S_DONE;
          case (cmd_e'(cmd_i))
            CMD_APPEND: begin
              if (not_full) begin
                mem_we   = 1'b1;
                count_d  = count_q + 1'b1;
                res_ok_d = 1'b1;
              end
            end
            CMD_INSERT: begin
              if (not_full && (posx <= cntx)) begin
                res_ok_d = 1'b1;
                if (posx == cntx) begin
                  mem_we  = 1'b1;
                  count_d = count_q + 1'b1;
                end else begin
                  mem_re    = 1'b1;
                  mem_raddr = cnt_m1x[AW-1:0];
                  rd_idx_d  = cnt_m1x[AW-1:0];
                  state_d   = S_UP;
                end
              end
            end
            CMD_REMOVE: begin
              if (posx < cntx) begin
                res_ok_d = 1'b1;
                if (posx == cnt_m1x) begin
                  count_d = count_q - 1'b1;
                end else begin
                  mem_re    = 1'b1;
                  mem_raddr = pos_p1x[AW-1:0];
                  rd_idx_d  = pos_p1x[AW-1:0];
                  state_d   = S_DN;
                end
              end
            end
            CMD_READ: begin
              if (posx < cntx) begin
                res_ok_d  = 1'b1;
                mem_re    = 1'b1;
                mem_raddr = posx[AW-1:0];
                state_d   = S_RDWAIT;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_RDWAIT: begin
        res_data_d = rd_ext;
        state_d    = S_DONE;
      end
      S_UP: begin
        mem_we    = 1'b1;
        mem_waddr = rd_idx_q + 1'b1;
        mem_wdata = mem_rdata;
        if (rd_idx_q == pos_q) begin
          state_d = S_INSWR;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = rd_idx_q - 1'b1;
          rd_idx_d  = rd_idx_q - 1'b1;
        end
      end
      S_INSWR: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q;
        mem_wdata = item_q;
        count_d   = count_q + 1'b1;
        state_d   = S_DONE;
      end
      S_DN: begin
        mem_we    = 1'b1;
        mem_waddr = rd_idx_q - 1'b1;
        mem_wdata = mem_rdata;
        if (CMPW'(rd_idx_q) == cnt_m1x) begin
          count_d = count_q - 1'b1;
          state_d = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = rd_idx_q + 1'b1;
          rd_idx_d  = rd_idx_q + 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q   <= rd_idx_d;
    pos_q      <= pos_d;
    item_q     <= item_d;
    res_ok_q   <= res_ok_d;
    res_data_q <= res_data_d;
    if ((state_q == S_DONE) && out_free) begin
      ok_q    <= res_ok_q;
      data_q  <= res_data_q;
      len_q   <= LEN_W'(count_q);
      empty_q <= (count_q == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign ok_o        = ok_q;
  assign read_data_o = data_q;
  assign length_o    = len_q;
  assign empty_res_o = empty_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("item count exceeds depth");

  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !ok_o) |-> (read_data_o == '0))
    else $error("refused request returned nonzero data");

  a_up_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UP) |-> (rd_idx_q >= pos_q))
    else $error("insert shift passed the insert position");

  a_dn_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DN) |-> (CMPW'(rd_idx_q) < cntx))
    else $error("remove shift read beyond the list end");

endmodule

// File: test/indexed_insert_remove_list_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for indexed_insert_remove_list: a local list model predicts
// every result; random requests run under random stalls on both sides, and long output stalls.
// Depends on idl_pkg and the indexed_insert_remove_list RTL only.
module indexed_insert_remove_list_tb;
  import idl_pkg::*;

  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic                    ok;
    logic signed [VAL_W-1:0] read_data;
    logic [LEN_W-1:0]        length;
    logic                    empty_res;
  } list_result_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic [CMD_W-1:0]        cmd_i;
  logic [POS_W-1:0]        position_i;
  logic signed [VAL_W-1:0] value_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic                    ok_o;
  logic signed [VAL_W-1:0] read_data_o;
  logic [LEN_W-1:0]        length_o;
  logic                    empty_res_o;

  logic signed [VAL_W-1:0] list_mem [DEPTH_DEF];
  int                      list_len;
  list_result_t            pending_results [$];
  list_result_t            exp_res;
  int                      results_seen;
  int                      results_paced;
  int                      mismatches;
  int                      rx_wait;
  bit                      tx_idle;
  bit                      rx_idle;
  bit                      hold_req;
  int                      cmd_count [4];
  int                      refused_count;
  int                      deepest_fill;

  indexed_insert_remove_list dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .position_i  (position_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ok_o        (ok_o),
    .read_data_o (read_data_o),
    .length_o    (length_o),
    .empty_res_o (empty_res_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic list_result_t apply_list_op(input cmd_e c, input logic [POS_W-1:0] p,
                                                 input logic signed [VAL_W-1:0] v);
    list_result_t r;
    int n;
    int pi;
    r = '0;
    n = list_len;
    pi = int'(p);
    case (c)
      CMD_APPEND: begin
        if (n < DEPTH_DEF) begin
          list_mem[n] = v;
          list_len++;
          r.ok = 1'b1;
        end
      end
      CMD_INSERT: begin
        if (n < DEPTH_DEF && pi <= n) begin
          for (int i = n; i > pi; i--) list_mem[i] = list_mem[i-1];
          list_mem[pi] = v;
          list_len++;
          r.ok = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (pi < n) begin
          for (int i = pi; i + 1 < n; i++) list_mem[i] = list_mem[i+1];
          list_len--;
          r.ok = 1'b1;
        end
      end
      default: begin
        if (pi < n) begin
          r.read_data = list_mem[pi];
          r.ok = 1'b1;
        end
      end
    endcase
    r.length = LEN_W'(list_len);
    r.empty_res = (list_len == 0);
    return r;
  endfunction

  task automatic send_request(input cmd_e c, input logic [POS_W-1:0] p,
                              input logic signed [VAL_W-1:0] v);
    list_result_t r;
    int gap;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    cmd_i      <= c;
    position_i <= p;
    value_i    <= v;
    do @(posedge clk_i); while (!in_ready_o);
    r = apply_list_op(c, p, v);
    pending_results.push_back(r);
    cmd_count[int'(c)]++;
    if (!r.ok) refused_count++;
    if (list_len > deepest_fill) deepest_fill = list_len;
    gap = tx_idle ? $urandom_range(0, 6) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_request(output cmd_e c, output logic [POS_W-1:0] p,
                                output logic signed [VAL_W-1:0] v);
    int top;
    if ($urandom_range(0, 99) < 8) begin
      c = cmd_e'($urandom_range(0, 3));
      p = POS_W'($urandom_range(0, 15));
    end else begin
      if ($urandom_range(0, 2) == 0) c = CMD_READ;
      else if ($urandom_range(0, 16) >= list_len) c = $urandom_range(0, 1) ? CMD_APPEND : CMD_INSERT;
      else c = CMD_REMOVE;
      top = (c == CMD_INSERT) ? list_len : list_len - 1;
      if (top > 15) top = 15;
      if (top < 0) top = 0;
      p = POS_W'($urandom_range(0, top));
    end
    case ($urandom_range(0, 19))
      0:       v = VAL_MIN;
      1:       v = VAL_MAX;
      2:       v = '0;
      3:       v = '1;
      default: v = $urandom;
    endcase
  endtask

  task automatic test_empty_list();
    send_request(CMD_READ, 4'd0, '0);
    send_request(CMD_REMOVE, 4'd0, '0);
    send_request(CMD_INSERT, 4'd1, 32'sh1234_5678);
    send_request(CMD_READ, 4'd15, '0);
    drain_results();
  endtask

  task automatic test_value_extremes();
    send_request(CMD_APPEND, 4'd9, VAL_MIN);
    send_request(CMD_APPEND, 4'd0, VAL_MAX);
    send_request(CMD_APPEND, 4'd0, '0);
    send_request(CMD_APPEND, 4'd0, '1);
    send_request(CMD_INSERT, 4'd0, 32'sh5555_5555);
    send_request(CMD_INSERT, 4'd5, 32'shaaaa_aaaa);
    send_request(CMD_INSERT, 4'd7, 32'sh0f0f_0f0f);
    send_request(CMD_READ, 4'd0, '0);
    send_request(CMD_READ, 4'd5, '0);
    send_request(CMD_REMOVE, 4'd0, '0);
    send_request(CMD_REMOVE, 4'd5, '0);
    send_request(CMD_REMOVE, 4'd4, '0);
    send_request(CMD_READ, 4'd4, '0);
    drain_results();
  endtask

  task automatic test_full_list();
    while (list_len < DEPTH_DEF) send_request(CMD_APPEND, 4'd0, $urandom);
    send_request(CMD_APPEND, 4'd0, 32'sh0bad_0bad);
    send_request(CMD_INSERT, 4'd3, 32'sh0bad_0bad);
    send_request(CMD_READ, 4'd15, '0);
    send_request(CMD_REMOVE, 4'd0, '0);
    send_request(CMD_INSERT, 4'd15, VAL_MIN);
    send_request(CMD_REMOVE, 4'd15, '0);
    send_request(CMD_READ, 4'd15, '0);
    drain_results();
  endtask

  task automatic test_output_stall();
    cmd_e c;
    logic [POS_W-1:0] p;
    logic signed [VAL_W-1:0] v;
    tx_idle = 1'b0;
    fork
      begin
        @(posedge clk_i);
        hold_req = 1'b1;
        repeat (80) @(posedge clk_i);
        hold_req = 1'b0;
      end
      begin
        repeat (12) begin
          random_request(c, p, v);
          send_request(c, p, v);
        end
      end
    join
    drain_results();
  endtask

  task automatic test_random_traffic();
    cmd_e c;
    logic [POS_W-1:0] p;
    logic signed [VAL_W-1:0] v;
    for (int seg = 0; seg < 10; seg++) begin
      tx_idle = (seg != 0) && ($urandom_range(0, 3) != 0);
      rx_idle = (seg != 0) && ($urandom_range(0, 3) != 0);
      if (seg == 5) drain_results();
      repeat (50) begin
        random_request(c, p, v);
        send_request(c, p, v);
      end
    end
    drain_results();
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (results_paced != results_seen) begin
        results_paced = results_seen;
        rx_wait = rx_idle ? $urandom_range(0, 6) : 0;
      end
      if (hold_req) begin
        out_ready_i <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        if (mismatches < 10) $display("Result with no request pending at %0t.", $realtime);
        mismatches++;
      end else begin
        exp_res = pending_results.pop_front();
        if (ok_o !== exp_res.ok || read_data_o !== exp_res.read_data ||
            length_o !== exp_res.length || empty_res_o !== exp_res.empty_res) begin
          if (mismatches < 10) begin
            $display("Mismatch at %0t: expected ok %0b data %0d length %0d empty %0b,",
                     $realtime, exp_res.ok, exp_res.read_data, exp_res.length,
                     exp_res.empty_res);
            $display("  got ok %0b data %0d length %0d empty %0b.",
                     ok_o, read_data_o, length_o, empty_res_o);
          end
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    cmd_i       = CMD_APPEND;
    position_i  = '0;
    value_i     = '0;
    out_ready_i = 1'b0;
    list_len    = 0;
    tx_idle     = 1'b1;
    rx_idle     = 1'b1;
    hold_req    = 1'b0;
    rx_wait     = 0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_empty_list();
    test_value_extremes();
    test_full_list();
    test_output_stall();
    tx_idle = 1'b1;
    test_random_traffic();
    repeat (40) @(posedge clk_i);
    $display("Ran %0d appends, %0d inserts, %0d removes and %0d reads; %0d were refused.",
             cmd_count[0], cmd_count[1], cmd_count[2], cmd_count[3], refused_count);
    $display("The list reached %0d items; %0d results were checked.", deepest_fill,
             results_seen);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("indexed_insert_remove_list_tb passed");
    end else begin
      $display("indexed_insert_remove_list_tb failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Timed out waiting for the list.");
    $display("indexed_insert_remove_list_tb failed");
    $finish;
  end

endmodule
